/* hdl/gcm_pkg.sv */
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared widths, codes, plan and remainder-unit types for the child gene
// string builder.
// ----------------------------------------------------------------------------
`default_nettype none

package gcm_pkg;

  localparam int unsigned MAX_WORDS = 256;
  localparam int unsigned WORD_CAP  = (MAX_WORDS < 256) ? MAX_WORDS : 256;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned RATE_W   = 17;
  localparam int unsigned GW_W     = 9;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned CFG_IX_W = 2;
  localparam int unsigned DIV_W    = 17;
  localparam int unsigned BITPOS_W = 13;
  localparam int unsigned BITS_W   = GW_W + 5;
  localparam int unsigned STEP_W   = 5;

  localparam logic [RATE_W-1:0] RATE_SCALE     = 17'd100000;
  localparam logic [GW_W-1:0]   GENE_WORDS_RST = 9'd1;
  localparam logic [GW_W-1:0]   GENE_WORDS_CAP = GW_W'(WORD_CAP);
  localparam logic [GW_W-1:0]   PLAN_WORD_RST  = GENE_WORDS_RST + 9'd1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_PAIR  = 1'b1;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_CROSS_RATE = 2'd0,
    CFG_MUT_RATE   = 2'd1,
    CFG_GENE_WORDS = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_CROSS_DECIDE = 2'd0,
    OP_CROSS_POINT  = 2'd1,
    OP_MUT_DECIDE   = 2'd2,
    OP_MUT_POINT    = 2'd3
  } plan_op_e;

  typedef struct packed {
    logic [GW_W-1:0]   cut_word;
    logic [WORD_W-1:0] cut_mask;
    logic [GW_W-1:0]   flip_word;
    logic [WORD_W-1:0] flip_mask;
  } plan_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [GW_W-1:0] eff_words(input logic [GW_W-1:0] gw);
    logic [GW_W-1:0] g;
    g = gw;
    if (g == '0) g = 9'd1;
    if (g > GENE_WORDS_CAP) g = GENE_WORDS_CAP;
    return g;
  endfunction

endpackage

`default_nettype wire

/* hdl/gcm_mod_unit.sv */
// ----------------------------------------------------------------------------
// gcm_mod_unit
// Iterative restoring remainder unit: 32-bit dividend, 17-bit divisor, one
// quotient bit per cycle, registered done pulse with the final remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module gcm_mod_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gcm_pkg::mod_req_t req_i,
  output gcm_pkg::mod_rsp_t      rsp_o
);
  import gcm_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [DIV_W-1:0]    rem_q, rem_d;
  logic [WORD_W-1:0]   dvd_q, dvd_d;
  logic [DIV_W-1:0]    dvs_q, dvs_d;
  logic [DIV_W:0]      trial;
  logic [DIV_W:0]      diff;

  assign trial = {rem_q, dvd_q[WORD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DIV_W-1:0];
      end else begin
        rem_d = trial[DIV_W-1:0];
      end
      dvd_d  = {dvd_q[WORD_W-2:0], 1'b0};
      step_d = step_q + 5'd1;
      if (step_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

/* hdl/gcm_planner.sv */
// ----------------------------------------------------------------------------
// gcm_planner
// Sequencer for a start item: runs four remainders through the shared unit
// and builds the crossover cut and mutation flip plan.
// ----------------------------------------------------------------------------
`default_nettype none

module gcm_planner (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [gcm_pkg::WORD_W-1:0]    rand_cross_decide_i,
  input  wire logic [gcm_pkg::WORD_W-1:0]    rand_cross_point_i,
  input  wire logic [gcm_pkg::WORD_W-1:0]    rand_mut_decide_i,
  input  wire logic [gcm_pkg::WORD_W-1:0]    rand_mut_point_i,
  input  wire logic [gcm_pkg::RATE_W-1:0]    cross_rate_i,
  input  wire logic [gcm_pkg::RATE_W-1:0]    mut_rate_i,
  input  wire logic [gcm_pkg::GW_W-1:0]      gene_words_i,
  output gcm_pkg::mod_req_t                  mod_req_o,
  input  wire gcm_pkg::mod_rsp_t             mod_rsp_i,
  output logic                               busy_o,
  output gcm_pkg::plan_t                     plan_o
);
  import gcm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LAUNCH = 3'b010,
    ST_WAIT   = 3'b100
  } plan_state_e;

  plan_state_e       state_q, state_d;
  plan_op_e          op_q, op_d;
  logic              cross_hit_q, cross_hit_d;
  logic              mut_hit_q, mut_hit_d;
  logic [GW_W-1:0]   words_q, words_d;
  logic [WORD_W-1:0] r_cd_q, r_cp_q, r_md_q, r_mp_q;
  plan_t             plan_q, plan_d;
  logic [BITS_W-1:0] bits;
  logic [BITPOS_W-1:0] pos;
  logic [BITPOS_W-1:0] cut_pos;

  assign bits    = {words_q, 5'b0};
  assign pos     = mod_rsp_i.rem[BITPOS_W-1:0];
  assign cut_pos = pos + 13'd1;

  always_comb begin
    mod_req_o.start    = (state_q == ST_LAUNCH);
    mod_req_o.dividend = r_cd_q;
    mod_req_o.divisor  = RATE_SCALE;
    unique case (op_q)
      OP_CROSS_DECIDE: begin
        mod_req_o.dividend = r_cd_q;
        mod_req_o.divisor  = RATE_SCALE;
      end
      OP_CROSS_POINT: begin
        mod_req_o.dividend = r_cp_q;
        mod_req_o.divisor  = DIV_W'(bits - 14'd1);
      end
      OP_MUT_DECIDE: begin
        mod_req_o.dividend = r_md_q;
        mod_req_o.divisor  = RATE_SCALE;
      end
      OP_MUT_POINT: begin
        mod_req_o.dividend = r_mp_q;
        mod_req_o.divisor  = DIV_W'(bits);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    cross_hit_d = cross_hit_q;
    mut_hit_d   = mut_hit_q;
    words_d     = words_q;
    plan_d      = plan_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_LAUNCH;
          op_d    = OP_CROSS_DECIDE;
          words_d = gene_words_i;
        end
      end
      ST_LAUNCH: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (mod_rsp_i.done) begin
          state_d = ST_LAUNCH;
          unique case (op_q)
            OP_CROSS_DECIDE: begin
              cross_hit_d = (mod_rsp_i.rem < cross_rate_i);
              op_d        = OP_CROSS_POINT;
            end
            OP_CROSS_POINT: begin
              if (cross_hit_q) begin
                plan_d.cut_word = GW_W'(cut_pos[BITPOS_W-1:5]);
                plan_d.cut_mask = (32'd1 << cut_pos[4:0]) - 32'd1;
              end else begin
                plan_d.cut_word = words_q + 9'd1;
                plan_d.cut_mask = '0;
              end
              op_d = OP_MUT_DECIDE;
            end
            OP_MUT_DECIDE: begin
              mut_hit_d = (mod_rsp_i.rem < mut_rate_i);
              op_d      = OP_MUT_POINT;
            end
            OP_MUT_POINT: begin
              if (mut_hit_q) begin
                plan_d.flip_word = GW_W'(pos[BITPOS_W-1:5]);
                plan_d.flip_mask = 32'd1 << pos[4:0];
              end else begin
                plan_d.flip_word = words_q + 9'd1;
                plan_d.flip_mask = '0;
              end
              state_d = ST_IDLE;
            end
            default: ;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      op_q             <= OP_CROSS_DECIDE;
      cross_hit_q      <= 1'b0;
      mut_hit_q        <= 1'b0;
      words_q          <= GENE_WORDS_RST;
      plan_q.cut_word  <= PLAN_WORD_RST;
      plan_q.cut_mask  <= '0;
      plan_q.flip_word <= PLAN_WORD_RST;
      plan_q.flip_mask <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      cross_hit_q <= cross_hit_d;
      mut_hit_q   <= mut_hit_d;
      words_q     <= words_d;
      plan_q      <= plan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == ST_IDLE)) begin
      r_cd_q <= rand_cross_decide_i;
      r_cp_q <= rand_cross_point_i;
      r_md_q <= rand_mut_decide_i;
      r_mp_q <= rand_mut_point_i;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign plan_o = plan_q;

endmodule

`default_nettype wire

/* hdl/gcm_word_path.sv */
// ----------------------------------------------------------------------------
// gcm_word_path
// Applies the plan to one mother/father word pair per item, tracks the word
// position and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gcm_word_path (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          pair_i,
  input  wire logic                          restart_i,
  input  wire logic [gcm_pkg::WORD_W-1:0]    mother_word_i,
  input  wire logic [gcm_pkg::WORD_W-1:0]    father_word_i,
  input  wire logic [gcm_pkg::GW_W-1:0]      gene_words_i,
  input  wire gcm_pkg::plan_t                plan_i,
  input  wire logic                          out_stall_i,
  output logic                               out_free_o,
  output logic                               out_valid_o,
  output logic [gcm_pkg::WORD_W-1:0]         child_word_o,
  output logic [gcm_pkg::IDX_W-1:0]          word_index_o,
  output logic                               last_o
);
  import gcm_pkg::*;

  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic              vld_q, vld_d;
  logic [WORD_W-1:0] word_q;
  logic [IDX_W-1:0]  idx_q;
  logic              last_q;
  logic [GW_W-1:0]   pos;
  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] child;
  logic              is_last;

  assign pos = {1'b0, cnt_q};

  always_comb begin
    if (pos < plan_i.cut_word) begin
      mixed = mother_word_i;
    end else if (pos > plan_i.cut_word) begin
      mixed = father_word_i;
    end else begin
      mixed = (mother_word_i & plan_i.cut_mask) | (father_word_i & ~plan_i.cut_mask);
    end
    child = (pos == plan_i.flip_word) ? (mixed ^ plan_i.flip_mask) : mixed;
  end

  assign is_last    = ((pos + 9'd1) >= gene_words_i);
  assign out_free_o = !vld_q || !out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    vld_d = vld_q;
    if (restart_i) begin
      cnt_d = '0;
    end else if (pair_i) begin
      cnt_d = is_last ? '0 : (cnt_q + 8'd1);
    end
    if (pair_i) begin
      vld_d = 1'b1;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pair_i) begin
      word_q <= child;
      idx_q  <= cnt_q;
      last_q <= is_last;
    end
  end

  assign out_valid_o  = vld_q;
  assign child_word_o = word_q;
  assign word_index_o = idx_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

/* hdl/ga_crossover_mutation.sv */
// ----------------------------------------------------------------------------
// ga_crossover_mutation
// Child gene string builder: single-point crossover and one-bit mutation.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): kind_i selects a start item,
// which carries four random draws, or a gene pair item, which carries the
// mother and father words at the current position.
// A start item yields no result. Its four remainders run one after another
// through one bit-serial remainder unit, so the block stalls its input
// after taking it until the plan is complete.
// A pair item yields one child word with its index and a last flag, in the
// output register in the cycle after acceptance; pair items stream at one per
// cycle while the output is not stalled. After the last word the position wraps to zero.
// Output channel (out_valid_o / out_stall_i): a stalled result holds, and
// the input stalls until the output register can take the next word.
// Configuration (cfg_valid_i / cfg_ready_o, always ready): index 0 crossover
// rate, 1 mutation rate, 2 gene words; write only while idle.
// Reset clears the rates, sets one gene word and a plan with no crossover
// and no mutation.
// ----------------------------------------------------------------------------
`default_nettype none

module ga_crossover_mutation (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [gcm_pkg::CFG_IX_W-1:0]  cfg_index_i,
  input  wire logic [gcm_pkg::RATE_W-1:0]    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          kind_i,
  input  wire logic [gcm_pkg::WORD_W-1:0]    rand_cross_decide_i,
  input  wire logic [gcm_pkg::WORD_W-1:0]    rand_cross_point_i,
  input  wire logic [gcm_pkg::WORD_W-1:0]    rand_mut_decide_i,
  input  wire logic [gcm_pkg::WORD_W-1:0]    rand_mut_point_i,
  input  wire logic [gcm_pkg::WORD_W-1:0]    mother_word_i,
  input  wire logic [gcm_pkg::WORD_W-1:0]    father_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [gcm_pkg::WORD_W-1:0]         child_word_o,
  output logic [gcm_pkg::IDX_W-1:0]          word_index_o,
  output logic                               last_o
);
  import gcm_pkg::*;

  logic [RATE_W-1:0] cross_rate_q;
  logic [RATE_W-1:0] mut_rate_q;
  logic [GW_W-1:0]   gene_words_q;
  logic [GW_W-1:0]   g_eff;
  logic              plan_busy;
  logic              out_free;
  logic              in_acc;
  logic              start_acc;
  logic              pair_acc;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;
  plan_t             plan;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cross_rate_q <= '0;
      mut_rate_q   <= '0;
      gene_words_q <= GENE_WORDS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CROSS_RATE: cross_rate_q <= cfg_data_i;
        CFG_MUT_RATE:   mut_rate_q   <= cfg_data_i;
        CFG_GENE_WORDS: gene_words_q <= cfg_data_i[GW_W-1:0];
        default: ;
      endcase
    end
  end

  assign g_eff      = eff_words(gene_words_q);
  assign in_stall_o = plan_busy || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start_acc  = in_acc && (kind_i == KIND_START);
  assign pair_acc   = in_acc && (kind_i == KIND_PAIR);

  gcm_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  gcm_planner u_planner (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_acc),
    .rand_cross_decide_i (rand_cross_decide_i),
    .rand_cross_point_i  (rand_cross_point_i),
    .rand_mut_decide_i   (rand_mut_decide_i),
    .rand_mut_point_i    (rand_mut_point_i),
    .cross_rate_i        (cross_rate_q),
    .mut_rate_i          (mut_rate_q),
    .gene_words_i        (g_eff),
    .mod_req_o           (mod_req),
    .mod_rsp_i           (mod_rsp),
    .busy_o              (plan_busy),
    .plan_o              (plan)
  );

  gcm_word_path u_word (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pair_i        (pair_acc),
    .restart_i     (start_acc),
    .mother_word_i (mother_word_i),
    .father_word_i (father_word_i),
    .gene_words_i  (g_eff),
    .plan_i        (plan),
    .out_stall_i   (out_stall_i),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .child_word_o  (child_word_o),
    .word_index_o  (word_index_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

/* hdl/gcm_checker.sv */
// ----------------------------------------------------------------------------
// gcm_checker
// Port-level checks on the child gene string builder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module gcm_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic kind_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i
);
  import gcm_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_start_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (kind_i == KIND_START)) |=> in_stall_o)
    else $error("input not stalled after start item");

  a_pair_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (kind_i == KIND_PAIR)) |=> out_valid_o)
    else $error("no result after pair item");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !(in_acc && (kind_i == KIND_PAIR))) |=> !out_valid_o)
    else $error("result repeated or invented");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while result is stalled");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

bind ga_crossover_mutation gcm_checker u_gcm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Child gene string builder testbench
// Drives start and gene pair items into ga_crossover_mutation with random
// gaps and output stalls. A predictor in the testbench keeps its own copy of
// the crossover and mutation plan and of the word position, and works out
// each child word. Every result is checked field by field in order. Directed
// tests cover the reset plan, the extreme random draws and rates, gene word
// counts out of range and a string that shrinks mid-child. A long random
// test follows, with many register settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gcm_pkg::*;

  localparam int unsigned RANDOM_ITEMS   = 1400;
  localparam int unsigned SETTLE_CYCLES  = 160;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] cross_decide;
    logic [WORD_W-1:0] cross_point;
    logic [WORD_W-1:0] mut_decide;
    logic [WORD_W-1:0] mut_point;
    logic [WORD_W-1:0] mother;
    logic [WORD_W-1:0] father;
  } gene_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  index;
    logic              last;
  } child_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CFG_IX_W-1:0] cfg_index_i;
  logic [RATE_W-1:0]   cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                kind_i;
  logic [WORD_W-1:0]   rand_cross_decide_i;
  logic [WORD_W-1:0]   rand_cross_point_i;
  logic [WORD_W-1:0]   rand_mut_decide_i;
  logic [WORD_W-1:0]   rand_mut_point_i;
  logic [WORD_W-1:0]   mother_word_i;
  logic [WORD_W-1:0]   father_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [WORD_W-1:0]   child_word_o;
  logic [IDX_W-1:0]    word_index_o;
  logic                last_o;

  // predictor copy of the registers and the plan
  logic [RATE_W-1:0] cross_rate_q;
  logic [RATE_W-1:0] mut_rate_q;
  logic [GW_W-1:0]   gene_words_q;
  logic [GW_W-1:0]   cut_word_q;
  logic [WORD_W-1:0] cut_mask_q;
  logic [GW_W-1:0]   flip_word_q;
  logic [WORD_W-1:0] flip_mask_q;
  logic [IDX_W-1:0]  position_q;

  child_word_t child_words_due[$];

  int  errors;
  int  n_items;
  int  n_starts;
  int  n_crossovers;
  int  n_mutations;
  int  n_checked;
  int  n_settings;
  int  stall_hold;
  int  idle_cycles;
  bit  tx_quiet;
  bit  rx_quiet;

  ga_crossover_mutation DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned live_gene_words();
    int unsigned g;
    g = gene_words_q;
    if (g == 0) g = 1;
    if (g > WORD_CAP) g = WORD_CAP;
    return g;
  endfunction

  task automatic predict_child(input gene_item_t it);
    int unsigned g;
    int unsigned bits;
    int unsigned n;
    int unsigned pos;
    logic [WORD_W-1:0] w;
    child_word_t due;
    g    = live_gene_words();
    bits = 32 * g;
    if (it.kind == KIND_START) begin
      n_starts++;
      cut_word_q = GW_W'(g + 1);
      cut_mask_q = '0;
      if (it.cross_decide % RATE_SCALE < cross_rate_q) begin
        n = 1 + it.cross_point % (bits - 1);
        cut_word_q = GW_W'(n / 32);
        cut_mask_q = (32'd1 << (n % 32)) - 32'd1;
        n_crossovers++;
      end
      flip_word_q = GW_W'(g + 1);
      flip_mask_q = '0;
      if (it.mut_decide % RATE_SCALE < mut_rate_q) begin
        n = it.mut_point % bits;
        flip_word_q = GW_W'(n / 32);
        flip_mask_q = 32'd1 << (n % 32);
        n_mutations++;
      end
      position_q = '0;
    end else begin
      pos = position_q;
      if (pos < cut_word_q) begin
        w = it.mother;
      end else if (pos > cut_word_q) begin
        w = it.father;
      end else begin
        w = (it.mother & cut_mask_q) | (it.father & ~cut_mask_q);
      end
      if (pos == flip_word_q) w = w ^ flip_mask_q;
      due.word  = w;
      due.index = position_q;
      due.last  = (pos + 1 >= g);
      child_words_due.push_back(due);
      position_q = due.last ? '0 : position_q + 1'b1;
    end
  endtask

  function automatic gene_item_t random_item(input logic kind);
    gene_item_t it;
    it.kind         = kind;
    it.cross_decide = $urandom;
    it.cross_point  = $urandom;
    it.mut_decide   = $urandom;
    it.mut_point    = $urandom;
    it.mother       = $urandom;
    it.father       = $urandom;
    return it;
  endfunction

  task automatic send_item(input gene_item_t it);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i          <= 1'b1;
    kind_i              <= it.kind;
    rand_cross_decide_i <= it.cross_decide;
    rand_cross_point_i  <= it.cross_point;
    rand_mut_decide_i   <= it.mut_decide;
    rand_mut_point_i    <= it.mut_point;
    mother_word_i       <= it.mother;
    father_word_i       <= it.father;
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
    predict_child(it);
  endtask

  task automatic send_pair(input logic [WORD_W-1:0] mother, input logic [WORD_W-1:0] father);
    gene_item_t it;
    it        = random_item(KIND_PAIR);
    it.mother = mother;
    it.father = father;
    send_item(it);
  endtask

  task automatic send_start(input logic [WORD_W-1:0] r1, input logic [WORD_W-1:0] r2,
                            input logic [WORD_W-1:0] r3, input logic [WORD_W-1:0] r4);
    gene_item_t it;
    it              = random_item(KIND_START);
    it.cross_decide = r1;
    it.cross_point  = r2;
    it.mut_decide   = r3;
    it.mut_point    = r4;
    send_item(it);
  endtask

  task automatic send_child(input int pairs);
    send_item(random_item(KIND_START));
    repeat (pairs) send_item(random_item(KIND_PAIR));
  endtask

  // stop sending and let every pending word and any start still in work finish
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (child_words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [RATE_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_CROSS_RATE: cross_rate_q = data;
      CFG_MUT_RATE:   mut_rate_q = data;
      CFG_GENE_WORDS: gene_words_q = data[GW_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic [RATE_W-1:0] cross_rate,
                           input logic [RATE_W-1:0] mut_rate,
                           input logic [RATE_W-1:0] gene_words);
    wait_idle();
    write_reg(CFG_CROSS_RATE, cross_rate);
    write_reg(CFG_MUT_RATE, mut_rate);
    write_reg(CFG_GENE_WORDS, gene_words);
    n_settings++;
  endtask

  // pairs before any start use the plan left by reset
  task automatic test_reset_plan();
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);
    configure(17'd0, 17'd0, 17'd4);
    repeat (5) send_pair(32'hA5A5_A5A5, 32'h5A5A_5A5A);
  endtask

  task automatic test_draw_extremes();
    configure(17'h1FFFF, 17'd100000, 17'd1);
    send_start(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);
    send_start(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    // zero gene words acts as one; a rate of one fires only on a draw whose remainder is zero
    configure(17'd1, 17'd100000, 17'd0);
    send_start(32'd0, $urandom, 32'd99999, $urandom);
    send_pair($urandom, $urandom);
    send_start(32'd1, $urandom, 32'd100000, $urandom);
    send_pair($urandom, $urandom);
    configure(17'd0, 17'd0, 17'd2);
    send_start(32'd0, $urandom, 32'd0, $urandom);
    send_pair($urandom, $urandom);
    send_pair($urandom, $urandom);
  endtask

  // gene word count shrinks while the position is beyond the new end
  task automatic test_shrink_mid_child();
    configure(17'd100000, 17'd100000, 17'd8);
    send_child(5);
    wait_idle();
    write_reg(CFG_GENE_WORDS, 17'd2);
    send_pair($urandom, $urandom);
    send_pair($urandom, $urandom);
  endtask

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return 17'd100000;
      2: return 17'h1FFFF;
      3: return 17'd1;
      4: return 17'd99999;
      default: return RATE_W'($urandom_range(0, 131071));
    endcase
  endfunction

  task automatic test_random_children();
    int base;
    int pick;
    int children;
    int g_eff;
    logic [GW_W-1:0] gw;
    bit first;
    base  = n_items;
    first = 1'b1;
    while (n_items - base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 31);
      if (first) gw = 9'd511;
      else if (pick == 0) gw = 9'd0;
      else if (pick == 1) gw = $urandom_range(0, 1) ? 9'd256 : GW_W'($urandom_range(257, 511));
      else if (pick < 6) gw = GW_W'($urandom_range(9, 40));
      else gw = GW_W'($urandom_range(1, 8));
      first = 1'b0;
      configure(pick_rate(), pick_rate(), {8'($urandom_range(0, 255)), gw});
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      g_eff    = live_gene_words();
      children = (g_eff > 64) ? 1 : $urandom_range(2, 8);
      repeat (children) begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, g_eff)) send_item(random_item(KIND_PAIR));
          1: send_child($urandom_range(0, g_eff - 1));
          2: begin
            send_item(random_item(KIND_START));
            send_child(g_eff);
          end
          default: send_child(g_eff);
        endcase
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] expected,
                             input logic [WORD_W-1:0] actual);
    if (expected !== actual) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
    end
  endtask

  initial begin
    child_word_t due;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (child_words_due.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected child word, expected none, actual %h index %0d last %0b",
                   $time, child_word_o, word_index_o, last_o);
        end else begin
          due = child_words_due.pop_front();
          check_field("child_word", due.word, child_word_o);
          check_field("word_index", WORD_W'(due.index), WORD_W'(word_index_o));
          check_field("last", WORD_W'(due.last), WORD_W'(last_o));
        end
        n_checked++;
        stall_hold = rx_quiet ? 0 : $urandom_range(0, 11);
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_hold != 0) begin
      out_stall_i <= 1'b1;
      stall_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    cfg_valid_i         = 1'b0;
    cfg_index_i         = CFG_CROSS_RATE;
    cfg_data_i          = '0;
    in_valid_i          = 1'b0;
    kind_i              = KIND_START;
    rand_cross_decide_i = '0;
    rand_cross_point_i  = '0;
    rand_mut_decide_i   = '0;
    rand_mut_point_i    = '0;
    mother_word_i       = '0;
    father_word_i       = '0;
    out_stall_i         = 1'b0;
    stall_hold          = 0;
    idle_cycles         = 0;
    tx_quiet            = 1'b0;
    rx_quiet            = 1'b0;
    cross_rate_q        = '0;
    mut_rate_q          = '0;
    gene_words_q        = GENE_WORDS_RST;
    cut_word_q          = PLAN_WORD_RST;
    cut_mask_q          = '0;
    flip_word_q         = PLAN_WORD_RST;
    flip_mask_q         = '0;
    position_q          = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_plan();
    test_draw_extremes();
    test_shrink_mid_child();
    test_random_children();
    wait_idle();

    if (child_words_due.size() != 0) begin
      errors++;
      $display("%0t ns: %0d child words never arrived", $time, child_words_due.size());
    end
    $display("Sent %0d items (%0d child starts) over %0d register settings, checked %0d words.",
             n_items, n_starts, n_settings, n_checked);
    $display("Plans with a crossover: %0d, with a mutation: %0d, errors: %0d.",
             n_crossovers, n_mutations, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
